>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition a at one edge implies condition b at the same edge.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Condition a at one edge implies condition b at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> src/ppia_pkg.sv
// ----------------------------------------------------------------------------
// ppia_pkg
// Types, constants and AES round functions for the IPv4 anonymizer.
// ----------------------------------------------------------------------------
package ppia_pkg;

    localparam int NUM_CELLS = 32;
    localparam int ROUNDS    = 14;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_KEY_0   = 3'd0,
        REG_KEY_1   = 3'd1,
        REG_KEY_2   = 3'd2,
        REG_KEY_3   = 3'd3,
        REG_PAD_HI  = 3'd4,
        REG_PAD_LO  = 3'd5,
        REG_IV_HI   = 3'd6,
        REG_IV_LO   = 3'd7
    } reg_index_t;

    // Configuration as seen by the cells.
    typedef struct packed {
        logic [255:0] key;
        logic [127:0] pad;
        logic [127:0] iv;
    } cfg_t;

    // Data handed from one cell to the next.
    typedef struct packed {
        logic         valid;
        logic [31:0]  addr;
        logic [31:0]  otp;
        logic [127:0] chain;
    } cell_link_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Round constant for a key expansion step, index 1 to 7.
    function automatic logic [7:0] rcon(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd1:    v = 8'h01;
            3'd2:    v = 8'h02;
            3'd3:    v = 8'h04;
            3'd4:    v = 8'h08;
            3'd5:    v = 8'h10;
            3'd6:    v = 8'h20;
            3'd7:    v = 8'h40;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
    // Byte 0 of the block sits in bits 127..120.
    function automatic logic [127:0] aes_round(input logic [127:0] din,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0]   t [16];
        logic [7:0]   s [16];
        logic [7:0]   all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[din[127 - 8 * i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                s[4 * c + i] = t[4 * ((c + i) % 4) + i];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                all = s[4 * c] ^ s[4 * c + 1] ^ s[4 * c + 2] ^ s[4 * c + 3];
                t[4 * c]     = s[4 * c] ^ all ^ xtime(s[4 * c] ^ s[4 * c + 1]);
                t[4 * c + 1] = s[4 * c + 1] ^ all ^ xtime(s[4 * c + 1] ^ s[4 * c + 2]);
                t[4 * c + 2] = s[4 * c + 2] ^ all ^ xtime(s[4 * c + 2] ^ s[4 * c + 3]);
                t[4 * c + 3] = s[4 * c + 3] ^ all ^ xtime(s[4 * c + 3] ^ s[4 * c]);
            end
            for (int i = 0; i < 16; i++) begin
                s[i] = t[i];
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = s[i];
        end
        return r ^ rk;
    endfunction

endpackage

>>> src/prefix_preserving_ipv4_anonymizer_core.sv
// ----------------------------------------------------------------------------
// prefix_preserving_ipv4_anonymizer_core
// Prefix-preserving IPv4 anonymizer with a chain of 32 AES-256 CBC cells.
// ----------------------------------------------------------------------------
//  channel   signals                                 direction
//  input     start, busy, address_in                 item in
//  result    result_valid, address_out               item out, one cycle
//  config    psel penable pwrite paddr pwdata        register write/read
//            prdata pready
//
// An item is taken only once the first cell has finished its 14-round loop
// (busy is high meanwhile); all 32 cells work on different items at once. Reset
// clears the cells' control state and sets the configuration registers to
// zero; the cell data registers are not reset. The result is shown for one
// cycle and cannot be stalled, so the chain never stops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prefix_preserving_ipv4_anonymizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] address_in,
    output logic        result_valid,
    output logic [31:0] address_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    ppia_pkg::cfg_t       cfg;
    ppia_pkg::cell_link_t links [ppia_pkg::NUM_CELLS + 1];
    logic [ppia_pkg::NUM_CELLS-1:0] cell_active;

    ppia_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The first cell takes a new item once its rounds are over.
    assign busy = cell_active[0];

    always_comb
    begin
        links[0].valid = start && !busy;
        links[0].addr  = address_in;
        links[0].otp   = 32'd0;
        links[0].chain = cfg.iv;
    end

    // Chain of cells, one per prefix length.
    for (genvar k = 0; k < ppia_pkg::NUM_CELLS; k++)
    begin : g_cell
        ppia_cell #(.POS(k)) u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .link_in  (links[k]),
            .link_out (links[k + 1]),
            .active   (cell_active[k])
        );
    end

    // Result: the address XORed with the collected pad.
    assign result_valid = links[ppia_pkg::NUM_CELLS].valid;
    assign address_out  = links[ppia_pkg::NUM_CELLS].addr ^ links[ppia_pkg::NUM_CELLS].otp;

    // Checks.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_result_single, clk, rst_n, result_valid, !result_valid)
    `ASSERT_SAME(a_first_done_free, clk, rst_n, links[1].valid, !busy)

endmodule

>>> src/ppia_regs.sv
// ----------------------------------------------------------------------------
// ppia_regs
// APB-style configuration registers: key, pad and chain IV.
// ----------------------------------------------------------------------------
module ppia_regs
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    output ppia_pkg::cfg_t       cfg
);

    logic [63:0] regs_reg [8];
    logic        wr_en;
    ppia_pkg::reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = ppia_pkg::reg_index_t'(paddr[5:3]);

    // Register writes; every index of the address decode is a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= 64'd0;
            end
        end
        else if (wr_en)
        begin
            regs_reg[idx] <= pwdata;
        end
    end

    assign prdata = regs_reg[idx];

    // Map the registers onto the configuration seen by the cells.
    assign cfg.key = {regs_reg[ppia_pkg::REG_KEY_0], regs_reg[ppia_pkg::REG_KEY_1],
                      regs_reg[ppia_pkg::REG_KEY_2], regs_reg[ppia_pkg::REG_KEY_3]};
    assign cfg.pad = {regs_reg[ppia_pkg::REG_PAD_HI], regs_reg[ppia_pkg::REG_PAD_LO]};
    assign cfg.iv  = {regs_reg[ppia_pkg::REG_IV_HI], regs_reg[ppia_pkg::REG_IV_LO]};

endmodule

>>> src/ppia_cell.sv
// ----------------------------------------------------------------------------
// ppia_cell
// One CBC block: forms the prefix block for its bit and runs AES-256 rounds.
// ----------------------------------------------------------------------------
module ppia_cell
#(
    parameter int POS = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppia_pkg::cfg_t        cfg,
    input  ppia_pkg::cell_link_t  link_in,
    output ppia_pkg::cell_link_t  link_out,
    output logic                  active
);

    localparam logic [31:0] MASK = ~(32'hFFFF_FFFF >> POS);
    localparam int OTP_BIT = 31 - POS;

    logic [127:0] st_reg, st_next;
    logic [255:0] win_reg, win_next;
    logic [31:0]  addr_reg, otp_reg;
    logic [3:0]   rnd_reg, rnd_next;
    logic         active_reg, active_next;
    logic         done_reg, done_next;

    logic [31:0]  word;
    logic [127:0] blk_in;
    logic [255:0] win_in;
    logic [3:0]   rnd_in;
    logic [31:0]  t;
    logic [31:0]  n0, n1, n2, n3;
    logic         run;

    // Plaintext block: top POS address bits, the rest from the pad.
    assign word = (link_in.addr & MASK) | (cfg.pad[127:96] & ~MASK);

    // A loaded item runs its first round in the load cycle itself.
    always_comb
    begin
        run = link_in.valid || active_reg;
        if (link_in.valid)
        begin
            blk_in = {word, cfg.pad[95:0]} ^ link_in.chain ^ cfg.key[255:128];
            win_in = cfg.key;
            rnd_in = 4'd1;
        end
        else
        begin
            blk_in = st_reg;
            win_in = win_reg;
            rnd_in = rnd_reg;
        end
    end

    // Key window slides by four words each round, alternating step kinds.
    always_comb
    begin
        if (rnd_in[0])
        begin
            t = ppia_pkg::sub_word({win_in[23:0], win_in[31:24]})
                ^ {ppia_pkg::rcon(3'((rnd_in + 4'd1) >> 1)), 24'd0};
        end
        else
        begin
            t = ppia_pkg::sub_word(win_in[31:0]);
        end
        n0 = win_in[255:224] ^ t;
        n1 = win_in[223:192] ^ n0;
        n2 = win_in[191:160] ^ n1;
        n3 = win_in[159:128] ^ n2;
        win_next = {win_in[127:0], n0, n1, n2, n3};
        st_next  = ppia_pkg::aes_round(blk_in, win_in[127:0],
                                       rnd_in == 4'(ppia_pkg::ROUNDS));
    end

    // Round sequencing.
    always_comb
    begin
        done_next   = active_reg && (rnd_reg == 4'(ppia_pkg::ROUNDS));
        active_next = link_in.valid || (active_reg && !done_next);
        rnd_next    = rnd_in + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            rnd_reg    <= 4'd0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            if (run)
            begin
                rnd_reg <= rnd_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            st_reg  <= st_next;
            win_reg <= win_next;
        end
        if (link_in.valid)
        begin
            addr_reg <= link_in.addr;
            otp_reg  <= link_in.otp;
        end
    end

    // Hand the ciphertext and the pad with this cell's bit to the next cell.
    always_comb
    begin
        link_out.valid   = done_reg;
        link_out.addr    = addr_reg;
        link_out.otp     = otp_reg;
        link_out.otp[OTP_BIT] = st_reg[127];
        link_out.chain   = st_reg;
    end

    assign active = active_reg;

endmodule

>>> test/ppia_checker.sv
// ----------------------------------------------------------------------------
// ppia_checker
// Watches the register port and both item channels of the anonymizer,
// computes the anonymized address of every accepted item and compares it
// with the result that comes out of the block.
// ----------------------------------------------------------------------------
module ppia_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] address_in,
    input  logic        result_valid,
    input  logic [31:0] address_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    // Shadow copy of the configuration registers.
    logic [255:0] key_shadow;
    logic [127:0] pad_shadow;
    logic [127:0] iv_shadow;

    // Anonymized addresses still to come out, oldest first.
    logic [31:0] anon_q [$];

    function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
        return {ppia_pkg::SBOX[w[31:24]], ppia_pkg::SBOX[w[23:16]],
                ppia_pkg::SBOX[w[15:8]], ppia_pkg::SBOX[w[7:0]]};
    endfunction

    // Full AES-256 round key schedule, 15 round keys.
    function automatic void build_schedule(input logic [255:0] key,
                                           output logic [127:0] rkeys [15]);
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            w[i] = key[255 - 32 * i -: 32];
        end
        for (int i = 8; i < 60; i++) begin
            t = w[i - 1];
            if (i % 8 == 0) begin
                t = {t[23:0], t[31:24]};
                t = sub_bytes32(t);
                t[31:24] = t[31:24] ^ rc;
                rc = {rc[6:0], 1'b0};
            end else if (i % 8 == 4) begin
                t = sub_bytes32(t);
            end
            w[i] = w[i - 8] ^ t;
        end
        for (int r = 0; r < 15; r++) begin
            rkeys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        end
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Encrypts one block; byte 0 sits in bits 127..120.
    function automatic logic [127:0] cipher_block(input logic [127:0] blk,
                                                  input logic [127:0] rkeys [15]);
        logic [7:0] st [16];
        logic [7:0] sub [16];
        logic [7:0] a0, a1, a2, a3, sum;
        logic [127:0] cur;
        cur = blk ^ rkeys[0];
        for (int r = 1; r <= 14; r++) begin
            for (int i = 0; i < 16; i++) begin
                sub[i] = ppia_pkg::SBOX[cur[127 - 8 * i -: 8]];
            end
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    st[4 * c + i] = sub[4 * ((c + i) % 4) + i];
                end
            end
            if (r != 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4 * c];
                    a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2];
                    a3 = st[4 * c + 3];
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ sum ^ gf_double(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ sum ^ gf_double(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ sum ^ gf_double(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ sum ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) begin
                cur[127 - 8 * i -: 8] = st[i];
            end
            cur = cur ^ rkeys[r];
        end
        return cur;
    endfunction

    // Builds one block per prefix length, chains them and collects the pad.
    function automatic logic [31:0] anonymize(input logic [31:0] addr);
        logic [127:0] rkeys [15];
        logic [127:0] chain;
        logic [31:0]  mask, word, otp;
        build_schedule(key_shadow, rkeys);
        chain = iv_shadow;
        otp = '0;
        for (int pos = 0; pos < 32; pos++) begin
            mask = (pos == 0) ? 32'h0 : (32'hffff_ffff << (32 - pos));
            word = (addr & mask) | (pad_shadow[127:96] & ~mask);
            chain = cipher_block({word, pad_shadow[95:0]} ^ chain, rkeys);
            otp[31 - pos] = chain[127];
        end
        return otp ^ addr;
    endfunction

    task automatic report(input string what, input logic [31:0] want,
                          input logic [31:0] got);
        $display("mismatch: %s expected %h got %h", what, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        checked = 0;
        key_shadow = '0;
        pad_shadow = '0;
        iv_shadow = '0;
    end

    // Track register writes, predict accepted items, compare results.
    always @(posedge clk) begin
        logic [31:0] want;
        if (rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (ppia_pkg::reg_index_t'(paddr[5:3]))
                    ppia_pkg::REG_KEY_0:  key_shadow[255:192] = pwdata;
                    ppia_pkg::REG_KEY_1:  key_shadow[191:128] = pwdata;
                    ppia_pkg::REG_KEY_2:  key_shadow[127:64]  = pwdata;
                    ppia_pkg::REG_KEY_3:  key_shadow[63:0]    = pwdata;
                    ppia_pkg::REG_PAD_HI: pad_shadow[127:64]  = pwdata;
                    ppia_pkg::REG_PAD_LO: pad_shadow[63:0]    = pwdata;
                    ppia_pkg::REG_IV_HI:  iv_shadow[127:64]   = pwdata;
                    ppia_pkg::REG_IV_LO:  iv_shadow[63:0]     = pwdata;
                    default:    ;
                endcase
            end
            if (start && !busy) begin
                anon_q.push_back(anonymize(address_in));
            end
            if (result_valid) begin
                if (anon_q.size() == 0) begin
                    report("unexpected result", 32'h0, address_out);
                end else begin
                    want = anon_q.pop_front();
                    checked++;
                    if (address_out !== want) begin
                        report("address_out", want, address_out);
                    end
                end
            end
            pending = anon_q.size();
        end
    end

endmodule

>>> test/tb_prefix_preserving_ipv4_anonymizer_core.sv
// ----------------------------------------------------------------------------
// tb_prefix_preserving_ipv4_anonymizer_core
// Drives addresses and register settings into the anonymizer core under
// several key, pad and IV settings with random gaps; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_prefix_preserving_ipv4_anonymizer_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 500;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] address_in;
    logic        result_valid;
    logic [31:0] address_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int sent;
    logic [31:0] last_addr;

    prefix_preserving_ipv4_anonymizer_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .address_in   (address_in),
        .result_valid (result_valid),
        .address_out  (address_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    ppia_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .address_in   (address_in),
        .result_valid (result_valid),
        .address_out  (address_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input ppia_pkg::reg_index_t idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] ph, input logic [63:0] pl,
                             input logic [63:0] ih, input logic [63:0] il);
        write_reg(ppia_pkg::REG_KEY_0, k0);
        write_reg(ppia_pkg::REG_KEY_1, k1);
        write_reg(ppia_pkg::REG_KEY_2, k2);
        write_reg(ppia_pkg::REG_KEY_3, k3);
        write_reg(ppia_pkg::REG_PAD_HI, ph);
        write_reg(ppia_pkg::REG_PAD_LO, pl);
        write_reg(ppia_pkg::REG_IV_HI, ih);
        write_reg(ppia_pkg::REG_IV_LO, il);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Half of the items back to back, most others after short gaps, rarely long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic [31:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        address_in <= addr;
        do begin
            @(posedge clk);
        end while (busy);
        @(negedge clk);
        sent++;
        last_addr = addr;
    endtask

    // Let every expected result arrive before touching the registers.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Random addresses, many sharing a prefix with the one before.
    task automatic random_phase(input int count);
        logic [31:0] a;
        int keep;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 2) == 0) begin
                keep = $urandom_range(1, 31);
                a = (last_addr & (32'hffff_ffff << (32 - keep)))
                    | ($urandom() & ~(32'hffff_ffff << (32 - keep)));
            end else begin
                a = $urandom();
            end
            send_item(a);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        address_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        last_addr = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers at their reset value: edge addresses and walking bits.
        send_item(32'h0000_0000);
        send_item(32'hffff_ffff);
        send_item(32'h8000_0000);
        send_item(32'h0000_0001);
        send_item(32'h7fff_ffff);
        send_item(32'hffff_fffe);
        send_item(32'haaaa_aaaa);
        send_item(32'h5555_5555);
        send_item(32'hc0a8_0001);
        send_item(32'hc0a8_0002);
        for (int b = 0; b < 32; b += 4) begin
            send_item(32'h1 << b);
        end
        random_phase(100);
        wait_idle();

        // All registers at all ones.
        write_all('1, '1, '1, '1, '1, '1, '1, '1);
        send_item(32'h0000_0000);
        send_item(32'hffff_ffff);
        random_phase(100);
        wait_idle();

        // Several random settings.
        for (int p = 0; p < 3; p++) begin
            write_all(rand64(), rand64(), rand64(), rand64(),
                      rand64(), rand64(), rand64(), rand64());
            random_phase(110);
            wait_idle();
        end

        // Back to zero, then a random key with a zero pad and IV.
        write_all('0, '0, '0, '0, '0, '0, '0, '0);
        send_item(32'hffff_ffff);
        wait_idle();
        write_all(rand64(), rand64(), rand64(), rand64(), '0, '0, '0, '0);
        random_phase(40);

        // Drain and give the verdict.
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("run covered %0d items over 7 register settings, %0d results checked",
                 sent, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
